// ----- src/pva_pkg.sv -----
package pva_pkg;

    localparam int ACTION_W = 8;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int DELTA_W  = 16;
    localparam int VIDX_W   = 3;

    localparam logic [ACTION_W-1:0] NOTE_ON  = 8'd144;
    localparam logic [ACTION_W-1:0] NOTE_OFF = 8'd128;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

endpackage

// ----- src/pva_if.sv -----
interface pva_event_if;
    import pva_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [NOTE_W-1:0]   note_number;
    logic [VEL_W-1:0]    velocity;
    logic [DELTA_W-1:0]  delta_ticks;

    modport source (output valid, action, note_number, velocity, delta_ticks, input ready);
    modport sink   (input valid, action, note_number, velocity, delta_ticks, output ready);
endinterface

interface pva_cmd_if;
    import pva_pkg::*;

    logic              valid;
    logic              ready;
    logic [VIDX_W-1:0] voice_index;
    logic              command;
    logic [NOTE_W-1:0] pitch;
    logic [VEL_W-1:0]  level;
    logic              last;

    modport source (output valid, voice_index, command, pitch, level, last, input ready);
    modport sink   (input valid, voice_index, command, pitch, level, last, output ready);
endinterface

// ----- src/pva_voice_mem.sv -----
module pva_voice_mem #(
    parameter int VOICES    = 8,
    parameter int TIME_BITS = 32,
    parameter int VW        = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [VW-1:0]        waddr,
    input  logic [6:0]           wnote,
    input  logic [TIME_BITS-1:0] wtime,
    input  logic [VW-1:0]        raddr,
    output logic [6:0]           rnote,
    output logic [TIME_BITS-1:0] rtime
);
    import pva_pkg::*;

    logic [NOTE_W+TIME_BITS-1:0] mem [VOICES];
    logic [NOTE_W+TIME_BITS-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wnote, wtime};
        end
        rdata_reg <= mem[raddr];
    end

    assign rnote = rdata_reg[NOTE_W+TIME_BITS-1:TIME_BITS];
    assign rtime = rdata_reg[TIME_BITS-1:0];
endmodule

// ----- src/pva_free_mem.sv -----
module pva_free_mem #(
    parameter int VOICES = 8,
    parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [VW-1:0] waddr,
    input  logic [VW-1:0] wdata,
    input  logic [VW-1:0] raddr,
    output logic [VW-1:0] rdata
);
    logic [VW-1:0]     mem [VOICES];
    logic [VOICES-1:0] written_reg;
    logic [VW-1:0]     rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (we)
        begin
            written_reg[waddr] <= 1'b1;
        end
    end

    // an entry never written reads as its reset value: descending voice numbers
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (written_reg[raddr])
        begin
            rdata_reg <= mem[raddr];
        end
        else
        begin
            rdata_reg <= VW'(VOICES - 1) - raddr;
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- src/poly_voice_allocator.sv -----
// Polyphonic voice allocator. Takes MIDI note events on the midi channel and issues
// start/release commands on the voice_cmd channel. Note-on takes the voice at the back of
// the free list; with every voice busy it first releases the voice with the oldest start
// time (lowest index on a tie), then starts the note on it, giving two commands. Note-off
// releases the lowest-numbered busy voice playing the note and puts it at the front of the
// free list; an unmatched note-off and any other status byte only advance the running time.
// One event is handled at a time. Note-off and note-on with every voice busy scan the voice
// table through its single read port (one voice per cycle); release and start commands
// wait while the command sink holds off ready. A finished command waits in an output
// register, so the next event can be taken meanwhile.
// Start times are compared raw, with no wrap correction of the running time.
module poly_voice_allocator #(
    parameter int VOICES    = 8,
    parameter int TIME_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    pva_event_if.sink midi,
    pva_cmd_if.source voice_cmd
);
    import pva_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int SW = $clog2(2 * VOICES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_POP   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_REL   = 5'b01000,
        S_START = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CW-1:0]        fc_reg, fc_next;
    logic [VW-1:0]        head_reg, head_next;
    logic [VOICES-1:0]    busy_reg, busy_next;
    logic [VW-1:0]        voice_reg, voice_next;
    logic [TIME_BITS-1:0] best_time_reg, best_time_next;
    logic [VW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic                 steal_reg, steal_next;
    logic                 is_on_reg, is_on_next;
    logic [NOTE_W-1:0]    note_reg, note_next;
    logic [VEL_W-1:0]     vel_reg, vel_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VIDX_W-1:0]    out_voice_reg, out_voice_next;
    logic                 out_cmd_reg, out_cmd_next;
    logic [NOTE_W-1:0]    out_pitch_reg, out_pitch_next;
    logic [VEL_W-1:0]     out_level_reg, out_level_next;
    logic                 out_last_reg, out_last_next;

    // memory ports
    logic                 vm_we;
    logic [VW-1:0]        vm_raddr;
    logic [NOTE_W-1:0]    vm_rnote;
    logic [TIME_BITS-1:0] vm_rtime;
    logic                 fm_we;
    logic [VW-1:0]        fm_waddr;
    logic [VW-1:0]        fm_raddr;
    logic [VW-1:0]        fm_rdata;

    logic                 accept;
    logic                 out_ok;
    logic [SW-1:0]        back_sum;
    logic [VW-1:0]        back_addr;
    logic [VW-1:0]        front_addr;
    logic                 scan_last;
    logic                 older;
    logic                 hit;

    assign midi.ready = (state_reg == S_IDLE);
    assign accept     = midi.valid && midi.ready;

    // output slot is free when empty or being drained this cycle
    assign out_ok = !out_valid_reg || voice_cmd.ready;

    // free list is a ring: logical entry i sits at (head + i) mod VOICES
    assign back_sum  = SW'(head_reg) + SW'(fc_reg) - SW'(1);
    assign back_addr = (back_sum >= SW'(VOICES)) ? VW'(back_sum - SW'(VOICES))
                                                 : VW'(back_sum);
    assign front_addr = (head_reg == '0) ? VW'(VOICES - 1) : head_reg - VW'(1);

    // scan compare on the voice entry read out for cmp_idx_reg
    assign scan_last = (cmp_idx_reg == VW'(VOICES - 1));
    assign older     = (cmp_idx_reg == '0) || (vm_rtime < best_time_reg);
    assign hit       = busy_reg[cmp_idx_reg] && (vm_rnote == note_reg) && !found_reg;

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        fc_next        = fc_reg;
        head_next      = head_reg;
        busy_next      = busy_reg;
        voice_next     = voice_reg;
        best_time_next = best_time_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        steal_next     = steal_reg;
        is_on_next     = is_on_reg;
        note_next      = note_reg;
        vel_next       = vel_reg;
        out_valid_next = out_valid_reg && !voice_cmd.ready;
        out_voice_next = out_voice_reg;
        out_cmd_next   = out_cmd_reg;
        out_pitch_next = out_pitch_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;
        vm_we          = 1'b0;
        vm_raddr       = '0;
        fm_we          = 1'b0;
        fm_waddr       = front_addr;
        fm_raddr       = back_addr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next     = now_reg + TIME_BITS'(midi.delta_ticks);
                    note_next    = midi.note_number;
                    vel_next     = midi.velocity;
                    cmp_idx_next = '0;
                    found_next   = 1'b0;
                    is_on_next   = (midi.action == NOTE_ON);
                    steal_next   = (midi.action == NOTE_ON) && (fc_reg == '0);
                    if (midi.action == NOTE_ON)
                    begin
                        // free list back read issued now, voice 0 read for a steal scan
                        state_next = (fc_reg == '0) ? S_SCAN : S_POP;
                    end
                    else if (midi.action == NOTE_OFF)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_POP:
            begin
                voice_next = fm_rdata;
                state_next = S_START;
            end

            S_SCAN:
            begin
                vm_raddr     = cmp_idx_reg + VW'(1);
                cmp_idx_next = cmp_idx_reg + VW'(1);
                if (is_on_reg)
                begin
                    if (older)
                    begin
                        voice_next     = cmp_idx_reg;
                        best_time_next = vm_rtime;
                    end
                end
                else if (hit)
                begin
                    voice_next = cmp_idx_reg;
                    found_next = 1'b1;
                end
                if (scan_last)
                begin
                    if (is_on_reg)
                    begin
                        state_next = S_REL;
                    end
                    else if ((found_reg || hit) && (fc_reg < CW'(VOICES)))
                    begin
                        state_next = S_REL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_REL:
            begin
                if (out_ok)
                begin
                    out_valid_next = 1'b1;
                    out_voice_next = VIDX_W'(voice_reg);
                    out_cmd_next   = CMD_RELEASE;
                    out_pitch_next = '0;
                    out_level_next = '0;
                    out_last_next  = !steal_reg;
                    if (steal_reg)
                    begin
                        // stolen voice is reused at once: busy stays, free list untouched
                        state_next = S_START;
                    end
                    else
                    begin
                        busy_next[voice_reg] = 1'b0;
                        fm_we                = 1'b1;
                        head_next            = front_addr;
                        fc_next              = fc_reg + CW'(1);
                        state_next           = S_IDLE;
                    end
                end
            end

            S_START:
            begin
                if (out_ok)
                begin
                    out_valid_next       = 1'b1;
                    out_voice_next       = VIDX_W'(voice_reg);
                    out_cmd_next         = CMD_START;
                    out_pitch_next       = note_reg;
                    out_level_next       = vel_reg;
                    out_last_next        = 1'b1;
                    vm_we                = 1'b1;
                    busy_next[voice_reg] = 1'b1;
                    if (!steal_reg)
                    begin
                        fc_next = fc_reg - CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            fc_reg        <= CW'(VOICES);
            head_reg      <= '0;
            busy_reg      <= '0;
            found_reg     <= 1'b0;
            steal_reg     <= 1'b0;
            is_on_reg     <= 1'b0;
            cmp_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            fc_reg        <= fc_next;
            head_reg      <= head_next;
            busy_reg      <= busy_next;
            found_reg     <= found_next;
            steal_reg     <= steal_next;
            is_on_reg     <= is_on_next;
            cmp_idx_reg   <= cmp_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        voice_reg     <= voice_next;
        best_time_reg <= best_time_next;
        note_reg      <= note_next;
        vel_reg       <= vel_next;
        out_voice_reg <= out_voice_next;
        out_cmd_reg   <= out_cmd_next;
        out_pitch_reg <= out_pitch_next;
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
    end

    // voice table: written only at the end of an event, read by the next event's scan,
    // so no scan read overlaps a write to the same entry
    pva_voice_mem #(
        .VOICES    (VOICES),
        .TIME_BITS (TIME_BITS),
        .VW        (VW)
    ) u_voice_mem (
        .clk   (clk),
        .we    (vm_we),
        .waddr (voice_reg),
        .wnote (note_reg),
        .wtime (now_reg),
        .raddr (vm_raddr),
        .rnote (vm_rnote),
        .rtime (vm_rtime)
    );

    pva_free_mem #(
        .VOICES (VOICES),
        .VW     (VW)
    ) u_free_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (voice_reg),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    assign voice_cmd.valid       = out_valid_reg;
    assign voice_cmd.voice_index = out_voice_reg;
    assign voice_cmd.command     = out_cmd_reg;
    assign voice_cmd.pitch       = out_pitch_reg;
    assign voice_cmd.level       = out_level_reg;
    assign voice_cmd.last        = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= CW'(VOICES))
        else $error("free count above voice count");

    a_busy_free_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(busy_reg) + int'(fc_reg)) == VOICES)
        else $error("busy voices and free count disagree");

    a_start_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START && !steal_reg) |-> !busy_reg[voice_reg])
        else $error("free list handed out a busy voice");

    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REL) |-> busy_reg[voice_reg])
        else $error("release of a voice that is not busy");

    a_steal_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && steal_reg) |-> (fc_reg == '0))
        else $error("steal scan with a free voice available");
endmodule
